/* sv/qoi_dec_pkg.sv */
`timescale 1ns / 1ps
// Shared types, chunk codes and helpers for the QOI chunk stream decoder.
// No dependencies; imported by every decoder module.
package qoi_dec_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int TAB_IDX_W       = $clog2(TABLE_ENTRIES);
    localparam int COUNT_BITS_DEF  = 24;
    localparam int PIX_COUNT_W     = 24;

    // chunk codes
    localparam logic [7:0] OP_RGB    = 8'hFE;
    localparam logic [7:0] OP_RGBA   = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    // channel select for the shared adder
    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    // bias constants folded into one addend (mod 256)
    localparam logic [7:0] DIFF_BIAS    = 8'd254;
    localparam logic [7:0] LUMA_G_BIAS  = 8'd224;
    localparam logic [7:0] LUMA_RB_BIAS = 8'd216;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RGB  = 2'd1,
        KIND_RGBA = 2'd2,
        KIND_LUMA = 2'd3
    } chunk_kind_t;

    // red in the low byte when viewed as a 32-bit word
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic                 en;
        logic [TAB_IDX_W-1:0] addr;
        pixel_t               data;
    } tab_wr_t;

    // (3r + 5g + 7b + 11a) mod 64, only the low six bits matter
    function automatic logic [TAB_IDX_W-1:0] qoi_hash(input pixel_t p);
        logic [TAB_IDX_W-1:0] h;
        h = TAB_IDX_W'(p.red) * TAB_IDX_W'(3) + TAB_IDX_W'(p.green) * TAB_IDX_W'(5)
          + TAB_IDX_W'(p.blue) * TAB_IDX_W'(7) + TAB_IDX_W'(p.alpha) * TAB_IDX_W'(11);
        return h;
    endfunction

endpackage

/* sv/qoi_dec_alu.sv */
`timescale 1ns / 1ps
// Shared channel adder: one 8-bit channel of a DIFF or LUMA chunk per cycle.
// Depends on qoi_dec_pkg.
module qoi_dec_alu
    import qoi_dec_pkg::*;
(
    input  logic        luma,
    input  logic [1:0]  ch,
    input  logic [7:0]  prev_val,
    input  logic [15:0] opnd,
    output logic [7:0]  result
);

    logic [7:0] b_op;
    logic [7:0] c_op;
    logic [7:0] d_op;

    always_comb begin
        b_op = '0;
        c_op = '0;
        d_op = '0;
        if (luma) begin
            // opnd[13:8] = dg, opnd[7:4] = dr-dg, opnd[3:0] = db-dg
            b_op = {2'b00, opnd[13:8]};
            unique case (ch)
                CH_R: begin
                    c_op = {4'h0, opnd[7:4]};
                    d_op = LUMA_RB_BIAS;
                end
                CH_G: begin
                    d_op = LUMA_G_BIAS;
                end
                CH_B: begin
                    c_op = {4'h0, opnd[3:0]};
                    d_op = LUMA_RB_BIAS;
                end
                default: begin
                    d_op = '0;
                end
            endcase
        end else begin
            d_op = DIFF_BIAS;
            unique case (ch)
                CH_R:    b_op = {6'h00, opnd[5:4]};
                CH_G:    b_op = {6'h00, opnd[3:2]};
                CH_B:    b_op = {6'h00, opnd[1:0]};
                default: b_op = '0;
            endcase
        end
    end

    assign result = prev_val + b_op + c_op + d_op;

endmodule

/* sv/qoi_dec_table.sv */
`timescale 1ns / 1ps
// Table of seen pixels: 64-entry memory with registered read and per-entry valid bits.
// Depends on qoi_dec_pkg.
module qoi_dec_table
    import qoi_dec_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [TAB_IDX_W-1:0] rd_addr,
    output pixel_t               rd_data,
    input  tab_wr_t              wr
);

    pixel_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    pixel_t                   rd_data_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* sv/qoi_image_stream_decoder_core.sv */
`timescale 1ns / 1ps
// QOI chunk stream decoder top level: sequencer, pixel state and output register.
// Depends on qoi_dec_pkg, qoi_dec_alu and qoi_dec_table.
//
// Usage:
//   s_t* carries the chunk stream one byte per word, starting right after the
//   header. m_t* carries one decoded pixel per word; m_tlast marks the final
//   pixel produced by one input byte, m_tuser flags the image's last pixel.
//   cfg_wr_en/cfg_wr_data set the pixel count (width * height); write it only
//   while the block is idle. Bytes arriving after the last pixel are dropped.
// Steps per input byte (receiver always ready):
//   chunk tail bytes and RGB/RGBA/LUMA head bytes: accept and gather
//   INDEX: accept, table read, output
//   DIFF, and the last byte of LUMA: accept, one channel at a time on the
//   shared adder, output; last byte of RGB/RGBA: accept, output
//   RUN of n pixels: accept, then one output word per cycle
//   s_tready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) clears the pixel count, the previous pixel
// (to opaque black), the table and the decode state at once; no sweep.
// A stalled receiver holds m_t* steady and freezes the sequencer at its next
// output; the block accepts the next byte once the pending pixel is loaded.
module qoi_image_stream_decoder_core
    import qoi_dec_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [PIX_COUNT_W-1:0] cfg_wr_data,   // pixel_count
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,       // byte_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,       // red, green, blue, alpha
    output logic                   m_tlast,       // last_of_run
    output logic [0:0]             m_tuser        // image_done
);

    localparam int CMP_W = (COUNT_BITS > PIX_COUNT_W) ? COUNT_BITS : PIX_COUNT_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INDEX = 5'b00010,
        ST_CALC  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_RUN   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    chunk_kind_t            kind_reg, kind_next;
    logic [2:0]             expect_reg, expect_next;
    logic [31:0]            gather_reg, gather_next;
    logic [15:0]            opnd_reg, opnd_next;
    logic                   luma_reg, luma_next;
    logic [1:0]             ch_reg, ch_next;
    pixel_t                 pix_reg, pix_next;
    pixel_t                 prev_reg, prev_next;
    logic [6:0]             run_left_reg, run_left_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [PIX_COUNT_W-1:0] pc_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    pixel_t                 m_pix_reg, m_pix_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_done_reg, m_done_next;

    logic                  s_fire;
    logic                  out_free;
    logic                  img_full;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      cnt_inc_ext;
    logic [CMP_W-1:0]      pc_ext;
    logic [31:0]           gather_sh;
    logic                  emit_fire;
    pixel_t                emit_pix;
    logic                  emit_last;
    logic                  tab_rd_en;
    pixel_t                tab_rd_data;
    tab_wr_t               tab_wr;
    logic [7:0]            alu_prev;
    logic [7:0]            alu_res;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign pc_ext      = CMP_W'(pc_reg);
    assign img_full    = CMP_W'(count_reg) >= pc_ext;
    assign count_inc   = count_reg + 1'b1;
    assign cnt_inc_ext = CMP_W'(count_inc);
    assign gather_sh   = {gather_reg[23:0], s_tdata};

    assign tab_rd_en = s_fire && !img_full && (kind_reg == KIND_NONE)
                    && (s_tdata[7:6] == TAG_INDEX);

    always_comb begin
        unique case (ch_reg)
            CH_R:    alu_prev = prev_reg.red;
            CH_G:    alu_prev = prev_reg.green;
            CH_B:    alu_prev = prev_reg.blue;
            default: alu_prev = prev_reg.red;
        endcase
    end

    qoi_dec_alu u_alu (
        .luma     (luma_reg),
        .ch       (ch_reg),
        .prev_val (alu_prev),
        .opnd     (opnd_reg),
        .result   (alu_res)
    );

    qoi_dec_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (tab_rd_en),
        .rd_addr (s_tdata[TAB_IDX_W-1:0]),
        .rd_data (tab_rd_data),
        .wr      (tab_wr)
    );

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        expect_next   = expect_reg;
        gather_next   = gather_reg;
        opnd_next     = opnd_reg;
        luma_next     = luma_reg;
        ch_next       = ch_reg;
        pix_next      = pix_reg;
        run_left_next = run_left_reg;
        emit_fire     = 1'b0;
        emit_pix      = pix_reg;
        emit_last     = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && !img_full) begin
                    if (kind_reg != KIND_NONE) begin
                        gather_next = gather_sh;
                        if (expect_reg != 3'd0) begin
                            expect_next = expect_reg - 3'd1;
                        end
                        if (expect_reg <= 3'd1) begin
                            // chunk complete
                            kind_next   = KIND_NONE;
                            gather_next = '0;
                            pix_next    = prev_reg;
                            unique case (kind_reg)
                                KIND_RGB: begin
                                    pix_next.red   = gather_sh[23:16];
                                    pix_next.green = gather_sh[15:8];
                                    pix_next.blue  = gather_sh[7:0];
                                    state_next     = ST_EMIT;
                                end
                                KIND_RGBA: begin
                                    pix_next.red   = gather_sh[31:24];
                                    pix_next.green = gather_sh[23:16];
                                    pix_next.blue  = gather_sh[15:8];
                                    pix_next.alpha = gather_sh[7:0];
                                    state_next     = ST_EMIT;
                                end
                                default: begin
                                    opnd_next  = gather_sh[15:0];
                                    luma_next  = 1'b1;
                                    ch_next    = CH_R;
                                    state_next = ST_CALC;
                                end
                            endcase
                        end
                    end else begin
                        priority if (s_tdata == OP_RGB) begin
                            kind_next   = KIND_RGB;
                            expect_next = 3'd3;
                            gather_next = '0;
                        end else if (s_tdata == OP_RGBA) begin
                            kind_next   = KIND_RGBA;
                            expect_next = 3'd4;
                            gather_next = '0;
                        end else begin
                            unique case (s_tdata[7:6])
                                TAG_INDEX: begin
                                    state_next = ST_INDEX;
                                end
                                TAG_DIFF: begin
                                    opnd_next  = {8'h00, s_tdata};
                                    luma_next  = 1'b0;
                                    ch_next    = CH_R;
                                    pix_next   = prev_reg;
                                    state_next = ST_CALC;
                                end
                                TAG_LUMA: begin
                                    kind_next   = KIND_LUMA;
                                    expect_next = 3'd1;
                                    gather_next = {24'h000000, s_tdata};
                                end
                                default: begin
                                    run_left_next = {1'b0, s_tdata[5:0]} + 7'd1;
                                    state_next    = ST_RUN;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_INDEX: begin
                pix_next   = tab_rd_data;
                state_next = ST_EMIT;
            end
            ST_CALC: begin
                unique case (ch_reg)
                    CH_R:    pix_next.red   = alu_res;
                    CH_G:    pix_next.green = alu_res;
                    CH_B:    pix_next.blue  = alu_res;
                    default: pix_next       = pix_reg;
                endcase
                if (ch_reg == CH_B) begin
                    state_next = ST_EMIT;
                end else begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                emit_pix = prev_reg;
                if (out_free) begin
                    emit_fire     = 1'b1;
                    run_left_next = run_left_reg - 7'd1;
                    emit_last     = (run_left_reg == 7'd1) || (cnt_inc_ext >= pc_ext);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        prev_next     = prev_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_pix_next    = m_pix_reg;
        m_last_next   = m_last_reg;
        m_done_next   = m_done_reg;
        if (emit_fire) begin
            prev_next     = emit_pix;
            count_next    = count_inc;
            m_tvalid_next = 1'b1;
            m_pix_next    = emit_pix;
            m_last_next   = emit_last;
            m_done_next   = (cnt_inc_ext == pc_ext);
        end
    end

    assign tab_wr = '{en: emit_fire, addr: qoi_hash(emit_pix), data: emit_pix};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_NONE;
            expect_reg   <= '0;
            gather_reg   <= '0;
            prev_reg     <= '{alpha: 8'hFF, blue: 8'h00, green: 8'h00, red: 8'h00};
            count_reg    <= '0;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            run_left_reg <= '0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            expect_reg   <= expect_next;
            gather_reg   <= gather_next;
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            run_left_reg <= run_left_next;
            if (cfg_wr_en) begin
                pc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg   <= opnd_next;
        luma_reg   <= luma_next;
        ch_reg     <= ch_next;
        pix_reg    <= pix_next;
        m_pix_reg  <= m_pix_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_pix_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_done_reg;

    // every loaded pixel advances the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> count_reg == $past(count_inc))
        else $error("pixel count did not advance on output load");

    // a run in progress always has pixels left
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (run_left_reg != 7'd0))
        else $error("run state with empty run length");

    // the image's last pixel always closes its byte's output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("image done without last-of-run");

    // a pending multi-byte chunk always expects more bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ((kind_reg == KIND_NONE) == (expect_reg == 3'd0)))
        else $error("pending chunk kind and byte count disagree");

    // no new byte is taken while an output load is due
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> !emit_fire)
        else $error("byte accepted during output load");

endmodule
